@@ rtl/core/dbsd_pkg.sv @@
// Package for the deflate block split detector: request codes, states,
// register indexes, reset values and the fixed constants of the split check.
// Used by the channel interfaces, the core and the checker.
package dbsd_pkg;

   localparam int COUNTER_BITS_DEFAULT = 16;

   localparam int MODE_BITS       = 2;
   localparam int VALUE_BITS      = 9;
   localparam int BLEN_BITS       = 16;
   localparam int COUNT_OUT_BITS  = 16;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 16;

   localparam int NUM_CLASSES  = 10;
   localparam int LIT_CLASSES  = 8;
   localparam int CLASS_BITS   = $clog2(NUM_CLASSES);

   localparam logic [COUNT_OUT_BITS-1:0] COUNT_OUT_MAX = '1;

   // split check constants
   localparam int SHORT_MATCH_LIMIT = 9;
   localparam int CUTOFF_SCALE      = 200;
   localparam int CUTOFF_SHIFT      = 9;      // divide by 512
   localparam int BLEN_LIMIT        = 10000;
   localparam int ITEMS_LIMIT       = 8192;
   localparam int ITEMS_SHIFT       = 13;     // divide by 8192
   localparam int BLEN_SHIFT        = 12;     // divide by 4096
   localparam int GROW_BITS         = 14;     // holds 8192 - items
   localparam int CUTOFF_SMALL_BITS = 25;     // cutoff bound while it may grow

   localparam logic [BLEN_BITS-1:0] MIN_BLOCK_LENGTH_RESET = 16'd5000;
   localparam logic [BLEN_BITS-1:0] CHECK_INTERVAL_RESET   = 16'd512;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_BLOCK_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHECK_INTERVAL   = 2'd1;

   // sequencer steps of a check
   localparam int CLASS_STEPS  = 2 * NUM_CLASSES;
   localparam int STEP_RATIO   = CLASS_STEPS;
   localparam int STEP_CUTOFF  = CLASS_STEPS + 1;
   localparam int STEP_BLEN    = CLASS_STEPS + 2;
   localparam int STEP_GROW    = CLASS_STEPS + 3;
   localparam int STEP_ADJUST  = CLASS_STEPS + 4;
   localparam int STEP_DECIDE  = CLASS_STEPS + 5;
   localparam int STEP_BITS    = $clog2(STEP_DECIDE + 1);

   typedef enum logic [MODE_BITS-1:0] {
      MODE_LITERAL = 2'd0,
      MODE_MATCH   = 2'd1,
      MODE_CHECK   = 2'd2,
      MODE_CLEAR   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MERGE
   } state_type;

endpackage

@@ rtl/core/dbsd_channels.sv @@
// Valid/ready channel interfaces of the block split detector: request,
// response and register write. Depends on dbsd_pkg.
interface dbsd_req_if import dbsd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   mode_type             mode;
   logic [VALUE_BITS-1:0] value;
   logic [BLEN_BITS-1:0] block_length;

   modport source (output valid, output mode, output value, output block_length,
                   input ready);
   modport sink   (input valid, input mode, input value, input block_length,
                   output ready);
endinterface

interface dbsd_rsp_if import dbsd_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      end_block;
   logic [COUNT_OUT_BITS-1:0] new_count;

   modport source (output valid, output end_block, output new_count, input ready);
   modport sink   (input valid, input end_block, input new_count, output ready);
endinterface

interface dbsd_csr_if import dbsd_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/dbsd_mult.sv @@
// Shared multiplier of the split check: one unsigned product per cycle,
// registered. Depends on dbsd_pkg.
module dbsd_mult import dbsd_pkg::*; #(
   parameter int A_BITS = 25,
   parameter int B_BITS = 16
) (
   input  logic                       clock,
   input  logic [A_BITS-1:0]          in_a,
   input  logic [B_BITS-1:0]          in_b,
   output logic [A_BITS+B_BITS-1:0]   product
);

   logic [A_BITS+B_BITS-1:0] product_ff;
   logic [A_BITS+B_BITS-1:0] product_in;

   assign product_in = (A_BITS+B_BITS)'(in_a) * (A_BITS+B_BITS)'(in_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

@@ rtl/core/deflate_block_split_detector.sv @@
// Channel   | Dir | Payload                          | Handshake
// req_bus   | in  | mode, value, block_length        | valid/ready
// rsp_bus   | out | end_block, new_count             | valid/ready
// csr_bus   | in  | index, data                      | valid/ready, always ready
//
// Literal, match and clear requests complete in the accept cycle; the
// response is registered and shows up in the next cycle. A check that is
// acted upon runs on the shared multiplier (two products per class, then
// the cutoff terms), then merges the class counts if the block does not
// end; with empty block counts it runs the merge only. One request is
// in flight at a time; a response that is not taken holds the request side.
// Reset is synchronous: it clears all counters and presets both registers.
// Depends on dbsd_pkg, dbsd_channels and dbsd_mult.
module deflate_block_split_detector import dbsd_pkg::*; #(
   parameter int COUNTER_BITS = COUNTER_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   dbsd_req_if.sink     req_bus,
   dbsd_rsp_if.source   rsp_bus,
   dbsd_csr_if.sink     csr_bus
);

   localparam int W  = COUNTER_BITS;
   localparam int MA = (W > CUTOFF_SMALL_BITS) ? W : CUTOFF_SMALL_BITS;
   localparam int MB = (W > GROW_BITS) ? W : GROW_BITS;
   localparam int PW = MA + MB;
   localparam int AW = 2 * W + 5;
   localparam int CW = 2 * W + 1;
   localparam int TW = (W > COUNT_OUT_BITS) ? W : COUNT_OUT_BITS;
   localparam int IW = (W + 1 > GROW_BITS) ? W + 1 : GROW_BITS;
   localparam logic [W-1:0] CNT_MAX = '1;

   function automatic logic [W-1:0] sat_add(input logic [W-1:0] a,
                                             input logic [W-1:0] b);
      logic [W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[W] ? CNT_MAX : sum[W-1:0];
   endfunction

   function automatic logic [COUNT_OUT_BITS-1:0] sat_out(input logic [W-1:0] v);
      logic [TW-1:0] x;
      x = TW'(v);
      return (x > TW'(COUNT_OUT_MAX)) ? COUNT_OUT_MAX : x[COUNT_OUT_BITS-1:0];
   endfunction

   state_type               state_ff, state_in;
   logic [STEP_BITS-1:0]    step_ff, step_in;

   logic [W-1:0]            blk_cnt_ff [NUM_CLASSES];
   logic [W-1:0]            blk_cnt_in [NUM_CLASSES];
   logic [W-1:0]            rec_cnt_ff [NUM_CLASSES];
   logic [W-1:0]            rec_cnt_in [NUM_CLASSES];
   logic [W-1:0]            blk_total_ff, blk_total_in;
   logic [W-1:0]            rec_total_ff, rec_total_in;

   logic [BLEN_BITS-1:0]    min_len_ff, min_len_in;
   logic [BLEN_BITS-1:0]    interval_ff, interval_in;
   logic [BLEN_BITS-1:0]    blen_ff, blen_in;

   logic [PW-1:0]           hold_ff, hold_in;
   logic [AW-1:0]           acc_ff, acc_in;
   logic [CW-1:0]           cutoff_ff, cutoff_in;
   logic                    grow_ff, grow_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_end_ff, rsp_end_in;
   logic [COUNT_OUT_BITS-1:0] rsp_count_ff, rsp_count_in;

   logic [CLASS_BITS-1:0]   idx;
   logic [W-1:0]            blk_rd, rec_rd;
   logic [MA-1:0]           mul_a;
   logic [MB-1:0]           mul_b;
   logic [PW-1:0]           prod;
   logic [PW-1:0]           abs_diff;
   logic [IW-1:0]           items;
   logic                    req_fire;
   logic                    acted;
   logic [CLASS_BITS-1:0]   obs_class;

   dbsd_mult #(.A_BITS(MA), .B_BITS(MB)) u_dbsd_mult (
      .clock   (clock),
      .in_a    (mul_a),
      .in_b    (mul_b),
      .product (prod)
   );

   assign req_bus.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.end_block = rsp_end_ff;
   assign rsp_bus.new_count = rsp_count_ff;

   // class of an observed symbol
   always_comb begin
      if (req_bus.mode == MODE_MATCH) begin
         obs_class = (req_bus.value >= VALUE_BITS'(SHORT_MATCH_LIMIT)) ?
                     CLASS_BITS'(LIT_CLASSES + 1) : CLASS_BITS'(LIT_CLASSES);
      end else begin
         obs_class = CLASS_BITS'({req_bus.value[7:6], req_bus.value[0]});
      end
   end

   // single read port into both counter rows
   always_comb begin
      unique case (state_ff)
         ST_CHECK: idx = step_ff[CLASS_BITS:1];
         ST_MERGE: idx = step_ff[CLASS_BITS-1:0];
         default:  idx = obs_class;
      endcase
   end

   assign blk_rd = blk_cnt_ff[idx];
   assign rec_rd = rec_cnt_ff[idx];

   assign items    = IW'(blk_total_ff) + IW'(rec_total_ff);
   assign abs_diff = (hold_ff > prod) ? hold_ff - prod : prod - hold_ff;
   assign acted    = (req_bus.block_length >= min_len_ff) &&
                     (TW'(rec_total_ff) >= TW'(interval_ff));

   // multiplier operands for each check step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_CHECK) begin
         if (step_ff < STEP_BITS'(CLASS_STEPS)) begin
            if (!step_ff[0]) begin
               mul_a = MA'(rec_rd);
               mul_b = MB'(blk_total_ff);
            end else begin
               mul_a = MA'(blk_rd);
               mul_b = MB'(rec_total_ff);
            end
         end else if (step_ff == STEP_BITS'(STEP_RATIO)) begin
            mul_a = MA'(rec_total_ff);
            mul_b = MB'(CUTOFF_SCALE);
         end else if (step_ff == STEP_BITS'(STEP_CUTOFF)) begin
            mul_a = MA'(prod[CUTOFF_SHIFT +: W]);
            mul_b = MB'(blk_total_ff);
         end else if (step_ff == STEP_BITS'(STEP_BLEN)) begin
            mul_a = MA'(blen_ff[BLEN_BITS-1:BLEN_SHIFT]);
            mul_b = MB'(blk_total_ff);
         end else if (step_ff == STEP_BITS'(STEP_GROW)) begin
            mul_a = MA'(cutoff_ff[CUTOFF_SMALL_BITS-1:0]);
            mul_b = MB'(GROW_BITS'(IW'(ITEMS_LIMIT) - items));
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      blk_cnt_in   = blk_cnt_ff;
      rec_cnt_in   = rec_cnt_ff;
      blk_total_in = blk_total_ff;
      rec_total_in = rec_total_ff;
      min_len_in   = min_len_ff;
      interval_in  = interval_ff;
      blen_in      = blen_ff;
      hold_in      = hold_ff;
      acc_in       = acc_ff;
      cutoff_in    = cutoff_ff;
      grow_in      = grow_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_end_in   = rsp_end_ff;
      rsp_count_in = rsp_count_ff;

      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_MIN_BLOCK_LENGTH: min_len_in  = csr_bus.data;
            CSR_CHECK_INTERVAL:   interval_in = csr_bus.data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               blen_in = req_bus.block_length;
               step_in = '0;
               acc_in  = '0;
               unique case (req_bus.mode) inside
                  MODE_LITERAL, MODE_MATCH: begin
                     rec_cnt_in[idx] = sat_add(rec_rd, W'(1));
                     rec_total_in    = sat_add(rec_total_ff, W'(1));
                     rsp_valid_in    = 1'b1;
                     rsp_end_in      = 1'b0;
                     rsp_count_in    = sat_out(rec_total_in);
                  end
                  MODE_CHECK: begin
                     if (!acted) begin
                        rsp_valid_in = 1'b1;
                        rsp_end_in   = 1'b0;
                        rsp_count_in = sat_out(rec_total_ff);
                     end else if (blk_total_ff == '0) begin
                        state_in = ST_MERGE;
                     end else begin
                        state_in = ST_CHECK;
                     end
                  end
                  default: begin
                     for (int i = 0; i < NUM_CLASSES; i++) begin
                        blk_cnt_in[i] = '0;
                        rec_cnt_in[i] = '0;
                     end
                     blk_total_in = '0;
                     rec_total_in = '0;
                     rsp_valid_in = 1'b1;
                     rsp_end_in   = 1'b0;
                     rsp_count_in = '0;
                  end
               endcase
            end
         end

         ST_CHECK: begin
            step_in = step_ff + STEP_BITS'(1);
            // consume the registered product of the previous step
            if (step_ff >= STEP_BITS'(1) && step_ff <= STEP_BITS'(CLASS_STEPS)) begin
               if (step_ff[0]) begin
                  hold_in = prod;
               end else begin
                  acc_in = acc_ff + AW'(abs_diff);
               end
            end
            if (step_ff == STEP_BITS'(STEP_BLEN)) begin
               cutoff_in = CW'(prod);
            end
            if (step_ff == STEP_BITS'(STEP_GROW)) begin
               acc_in  = acc_ff + AW'(prod);
               grow_in = (blen_ff < BLEN_BITS'(BLEN_LIMIT)) &&
                         (items < IW'(ITEMS_LIMIT));
            end
            if (step_ff == STEP_BITS'(STEP_ADJUST) && grow_ff) begin
               cutoff_in = cutoff_ff + CW'(prod >> ITEMS_SHIFT);
            end
            if (step_ff == STEP_BITS'(STEP_DECIDE)) begin
               step_in = '0;
               if (acc_ff >= AW'(cutoff_ff)) begin
                  // diverged: leave counts for the clear at the boundary
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_end_in   = 1'b1;
                  rsp_count_in = sat_out(rec_total_ff);
               end else begin
                  state_in = ST_MERGE;
               end
            end
         end

         ST_MERGE: begin
            blk_cnt_in[idx] = sat_add(blk_rd, rec_rd);
            rec_cnt_in[idx] = '0;
            step_in         = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(NUM_CLASSES - 1)) begin
               blk_total_in = sat_add(blk_total_ff, rec_total_ff);
               rec_total_in = '0;
               step_in      = '0;
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_end_in   = 1'b0;
               rsp_count_in = '0;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         blk_total_ff <= '0;
         rec_total_ff <= '0;
         min_len_ff   <= MIN_BLOCK_LENGTH_RESET;
         interval_ff  <= CHECK_INTERVAL_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            blk_cnt_ff[i] <= '0;
            rec_cnt_ff[i] <= '0;
         end
      end else begin
         step_ff      <= step_in;
         blk_total_ff <= blk_total_in;
         rec_total_ff <= rec_total_in;
         min_len_ff   <= min_len_in;
         interval_ff  <= interval_in;
         rsp_valid_ff <= rsp_valid_in;
         blk_cnt_ff   <= blk_cnt_in;
         rec_cnt_ff   <= rec_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      blen_ff      <= blen_in;
      hold_ff      <= hold_in;
      acc_ff       <= acc_in;
      cutoff_ff    <= cutoff_in;
      grow_ff      <= grow_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_count_ff <= rsp_count_in;
   end

endmodule

@@ rtl/core/dbsd_checker.sv @@
// Port-level checks on the block split detector and the bind that attaches
// them. Depends on dbsd_pkg and deflate_block_split_detector.
module dbsd_checker import dbsd_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic [MODE_BITS-1:0]      req_mode,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_end_block,
   input logic [COUNT_OUT_BITS-1:0] rsp_new_count
);

   logic req_fire;
   assign req_fire = req_valid && req_ready;

   // symbol and clear requests answer in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_mode != MODE_CHECK) |=> rsp_valid)
      else $error("symbol or clear request without response next cycle");

   // a clear leaves nothing counted
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_mode == MODE_CLEAR) |=> (!rsp_end_block && rsp_new_count == '0))
      else $error("clear response not zero");

   // hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_end_block) && $stable(rsp_new_count)))
      else $error("stalled response changed");

   // no response right after reset
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind deflate_block_split_detector dbsd_checker u_dbsd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .req_mode      (req_bus.mode),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_end_block (rsp_bus.end_block),
   .rsp_new_count (rsp_bus.new_count)
);
